FILE: sv/tlf_pkg.sv
// shared types, constants and helpers for the text line filter
package tlf_pkg;

  // default count of line number digits
  localparam int NUMBER_DIGITS_DEF = 6;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // configuration port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUMBER_ALL       = 3'd0,
    CFG_NUMBER_NONBLANK  = 3'd1,
    CFG_SQUEEZE_BLANK    = 3'd2,
    CFG_SHOW_LINE_ENDS   = 3'd3,
    CFG_SHOW_TABS        = 3'd4,
    CFG_SHOW_NONPRINTING = 3'd5
  } cfg_idx_t;

  // configuration register bank
  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_line_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  // escape prefix that goes before the final byte
  typedef enum logic [1:0] {
    PRE_NONE  = 2'd0,
    PRE_CARET = 2'd1,
    PRE_META  = 2'd2
  } pre_t;

  // character codes
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_QMARK    = 8'h3F;
  localparam logic [7:0] CH_I        = 8'h49;
  localparam logic [7:0] CH_M        = 8'h4D;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CH_META_LO  = 8'h80;
  localparam logic [7:0] CH_META_HI  = 8'h9F;
  localparam logic [7:0] CTRL_OFFSET = 8'h40;

  // width of one queued command for a given digit count
  function automatic int cmd_width(input int digits);
    return 4 * digits + 12;
  endfunction

endpackage

FILE: sv/tlf_if.sv
// stream interfaces for the input bytes and the output bytes

// input channel
interface tlf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_file;

  modport source (output valid, output in_byte, output start_of_file, input ready);
  modport sink   (input valid, input in_byte, input start_of_file, output ready);
endinterface

// output channel
interface tlf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

FILE: sv/tlf_queue.sv
// small register queue between the front and the back
module tlf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: sv/tlf_front.sv
// front end: config registers, line state and byte classification
module tlf_front #(
  parameter int NUMBER_DIGITS = tlf_pkg::NUMBER_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tlf_in_if.sink                        in_if,
  input  logic                          cfg_we,
  input  logic [tlf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tlf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [tlf_pkg::cmd_width(NUMBER_DIGITS)-1:0] q_wdata
);

  localparam int LN_W = 4 * NUMBER_DIGITS;

  typedef struct packed {
    logic              has_num;
    logic [LN_W-1:0]   num;
    logic              dollar;
    tlf_pkg::pre_t     pre;
    logic [7:0]        chr;
  } cmd_t;

  tlf_pkg::cfg_t   cfg_r;
  logic            prev_nl_r, prev_nl_nxt;
  logic [LN_W-1:0] line_num_r, line_num_nxt;
  logic [1:0]      blank_run_r, blank_run_nxt;

  logic            accept;
  logic            is_nl;
  logic            drop;
  logic            do_number;
  logic            prev_nl_eff;
  logic [LN_W-1:0] line_num_eff;
  logic [LN_W-1:0] line_num_inc;
  logic [1:0]      blank_run_eff;
  cmd_t            cmd;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && in_if.ready;
  assign is_nl       = (in_if.in_byte == tlf_pkg::CH_NL);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (tlf_pkg::cfg_idx_t'(cfg_index))
        tlf_pkg::CFG_NUMBER_ALL:       cfg_r.number_all       <= cfg_wdata[0];
        tlf_pkg::CFG_NUMBER_NONBLANK:  cfg_r.number_nonblank  <= cfg_wdata[0];
        tlf_pkg::CFG_SQUEEZE_BLANK:    cfg_r.squeeze_blank    <= cfg_wdata[0];
        tlf_pkg::CFG_SHOW_LINE_ENDS:   cfg_r.show_line_ends   <= cfg_wdata[0];
        tlf_pkg::CFG_SHOW_TABS:        cfg_r.show_tabs        <= cfg_wdata[0];
        tlf_pkg::CFG_SHOW_NONPRINTING: cfg_r.show_nonprinting <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // start of file clears the line state first
  assign prev_nl_eff   = in_if.start_of_file ? 1'b1 : prev_nl_r;
  assign line_num_eff  = in_if.start_of_file ? '0 : line_num_r;
  assign blank_run_eff = in_if.start_of_file ? 2'd0 : blank_run_r;

  // bcd increment, saturating at all nines
  always_comb begin
    logic       carry;
    logic [3:0] d;
    carry        = 1'b1;
    line_num_inc = line_num_eff;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      d = line_num_eff[4*i +: 4];
      if (carry) begin
        line_num_inc[4*i +: 4] = (d >= 4'd9) ? 4'd0 : d + 4'd1;
      end
      carry = carry && (d == 4'd9);
    end
    if (carry) begin
      line_num_inc = line_num_eff;
    end
  end

  // squeeze check, then numbering
  always_comb begin
    blank_run_nxt = blank_run_eff;
    drop          = 1'b0;
    if (cfg_r.squeeze_blank) begin
      if (is_nl && prev_nl_eff) begin
        blank_run_nxt = (blank_run_eff == 2'd2) ? 2'd2 : blank_run_eff + 2'd1;
        drop          = (blank_run_nxt == 2'd2);
      end else begin
        blank_run_nxt = 2'd0;
      end
    end
    do_number = prev_nl_eff &&
                (cfg_r.number_all || (cfg_r.number_nonblank && !is_nl));
    if (drop) begin
      prev_nl_nxt  = prev_nl_eff;
      line_num_nxt = line_num_eff;
    end else begin
      prev_nl_nxt  = is_nl;
      line_num_nxt = do_number ? line_num_inc : line_num_eff;
    end
  end

  // command classification
  always_comb begin
    cmd.has_num = do_number;
    cmd.num     = line_num_nxt;
    cmd.dollar  = cfg_r.show_line_ends && is_nl;
    cmd.pre     = tlf_pkg::PRE_NONE;
    cmd.chr     = in_if.in_byte;
    if (cfg_r.show_tabs && (in_if.in_byte == tlf_pkg::CH_TAB)) begin
      cmd.pre = tlf_pkg::PRE_CARET;
      cmd.chr = tlf_pkg::CH_I;
    end else if (cfg_r.show_nonprinting) begin
      if ((in_if.in_byte < tlf_pkg::CH_SPACE) && (in_if.in_byte != tlf_pkg::CH_TAB) &&
          !is_nl) begin
        cmd.pre = tlf_pkg::PRE_CARET;
        cmd.chr = in_if.in_byte + tlf_pkg::CTRL_OFFSET;
      end else if (in_if.in_byte == tlf_pkg::CH_DEL) begin
        cmd.pre = tlf_pkg::PRE_CARET;
        cmd.chr = tlf_pkg::CH_QMARK;
      end else if ((in_if.in_byte >= tlf_pkg::CH_META_LO) &&
                   (in_if.in_byte <= tlf_pkg::CH_META_HI)) begin
        cmd.pre = tlf_pkg::PRE_META;
        cmd.chr = in_if.in_byte - tlf_pkg::CTRL_OFFSET;
      end
    end
  end

  assign q_push  = accept && !drop;
  assign q_wdata = cmd;

  // line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_nl_r   <= 1'b1;
      line_num_r  <= '0;
      blank_run_r <= 2'd0;
    end else if (accept) begin
      prev_nl_r   <= prev_nl_nxt;
      line_num_r  <= line_num_nxt;
      blank_run_r <= blank_run_nxt;
    end
  end

endmodule

FILE: sv/tlf_back.sv
// back end: expands one queued command into its output bytes
module tlf_back #(
  parameter int NUMBER_DIGITS = tlf_pkg::NUMBER_DIGITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_empty,
  input  logic [tlf_pkg::cmd_width(NUMBER_DIGITS)-1:0] q_rdata,
  output logic  q_pop,
  tlf_out_if.source out_if
);

  localparam int LN_W = 4 * NUMBER_DIGITS;
  localparam int CW   = (NUMBER_DIGITS + 1 > 3) ? $clog2(NUMBER_DIGITS + 1) : 2;

  typedef struct packed {
    logic              has_num;
    logic [LN_W-1:0]   num;
    logic              dollar;
    tlf_pkg::pre_t     pre;
    logic [7:0]        chr;
  } cmd_t;

  typedef enum logic [3:0] {
    PH_NUM    = 4'b0001,
    PH_DOLLAR = 4'b0010,
    PH_PRE    = 4'b0100,
    PH_BYTE   = 4'b1000
  } phase_t;

  cmd_t          head;
  phase_t        phase_r, phase_nxt;
  logic          started_r, started_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;

  phase_t        cur_ph;
  phase_t        start_ph;
  phase_t        after_num_ph;
  phase_t        after_dollar_ph;
  phase_t        next_ph;
  logic [CW-1:0] cur_cnt;
  logic          ph_end;
  logic          advance;
  logic          fire;
  logic [7:0]    dchar [NUMBER_DIGITS];
  logic [7:0]    num_char;

  assign head    = cmd_t'(q_rdata);
  assign advance = !out_valid_r || out_if.ready;
  assign fire    = advance && !q_empty;

  // phase order: number, dollar, prefix, byte
  assign after_dollar_ph = (head.pre != tlf_pkg::PRE_NONE) ? PH_PRE : PH_BYTE;
  assign after_num_ph    = head.dollar ? PH_DOLLAR : after_dollar_ph;
  assign start_ph        = head.has_num ? PH_NUM : after_num_ph;
  assign cur_ph          = started_r ? phase_r : start_ph;
  assign cur_cnt         = started_r ? cnt_r : '0;

  // digit characters with leading blanks
  always_comb begin
    logic       zero_above;
    logic [3:0] d;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      zero_above = 1'b1;
      for (int j = 0; j < NUMBER_DIGITS; j++) begin
        if ((j >= i) && (head.num[4*j +: 4] != 4'd0)) begin
          zero_above = 1'b0;
        end
      end
      d = head.num[4*i +: 4];
      if (d > 4'd9) begin
        d = 4'd9;
      end
      dchar[i] = (zero_above && (i != 0)) ? tlf_pkg::CH_SPACE
                                          : tlf_pkg::CH_ZERO + {4'b0000, d};
    end
  end

  // most significant digit first, then the tab
  always_comb begin
    num_char = tlf_pkg::CH_TAB;
    for (int k = 0; k < NUMBER_DIGITS; k++) begin
      if (cur_cnt == CW'(k)) begin
        num_char = dchar[NUMBER_DIGITS - 1 - k];
      end
    end
  end

  // byte selection for the current phase
  always_comb begin
    out_byte_nxt = head.chr;
    out_last_nxt = 1'b0;
    ph_end       = 1'b1;
    next_ph      = PH_BYTE;
    case (cur_ph)
      PH_NUM: begin
        out_byte_nxt = num_char;
        ph_end       = (cur_cnt == CW'(NUMBER_DIGITS));
        next_ph      = after_num_ph;
      end
      PH_DOLLAR: begin
        out_byte_nxt = tlf_pkg::CH_DOLLAR;
        next_ph      = after_dollar_ph;
      end
      PH_PRE: begin
        if (head.pre == tlf_pkg::PRE_META) begin
          case (cur_cnt)
            CW'(0):  out_byte_nxt = tlf_pkg::CH_M;
            CW'(1):  out_byte_nxt = tlf_pkg::CH_DASH;
            default: out_byte_nxt = tlf_pkg::CH_CARET;
          endcase
          ph_end = (cur_cnt == CW'(2));
        end else begin
          out_byte_nxt = tlf_pkg::CH_CARET;
        end
      end
      PH_BYTE: begin
        out_byte_nxt = head.chr;
        out_last_nxt = 1'b1;
      end
      default: begin
        out_byte_nxt = head.chr;
        out_last_nxt = 1'b1;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    started_nxt = started_r;
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    if (fire) begin
      started_nxt = !out_last_nxt;
      phase_nxt   = ph_end ? next_ph : cur_ph;
      cnt_nxt     = (ph_end || out_last_nxt) ? '0 : cur_cnt + 1'b1;
    end
  end

  assign q_pop = fire && out_last_nxt;

  // sequencer and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      phase_r     <= PH_NUM;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      started_r <= started_nxt;
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (advance) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r <= out_byte_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.out_byte    = out_byte_r;
  assign out_if.last_of_run = out_last_r;

endmodule

FILE: sv/text_line_filter_with_escapes_top.sv
// top level of the text line filter with escapes
// the first output byte of an accepted input passes through the command queue and then the output register
// throughput: one input transaction per cycle while each yields one output byte and the output is not stalled
// an input that yields n bytes holds the output sequencer until all n are issued (n up to digits + 5)
// the two-entry command queue lets the input side run ahead of the output sequencer
// reset: synchronous active-low rst_n clears config, line state, queue and output valid
module text_line_filter_with_escapes_top #(
  parameter int NUMBER_DIGITS = tlf_pkg::NUMBER_DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tlf_in_if.sink                         in_if,
  tlf_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [tlf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CMD_W = tlf_pkg::cmd_width(NUMBER_DIGITS);

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [CMD_W-1:0] q_wdata;
  logic [CMD_W-1:0] q_rdata;

  // classification and line state
  tlf_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // command queue
  tlf_queue #(
    .WIDTH(CMD_W),
    .DEPTH(tlf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  // output byte sequencer
  tlf_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_empty(q_empty),
    .q_rdata(q_rdata),
    .q_pop  (q_pop),
    .out_if (out_if)
  );

endmodule

FILE: sv/tlf_checker.sv
// port-level checks for the text line filter, bound to the top level
module tlf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // output side is empty right after reset
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // input stalls only while output is backed up
  a_stall_needs_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output register");

  // a burst continues without gaps once started
  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> out_valid)
    else $error("gap inside an output burst");

  // stalled output transaction keeps valid
  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output valid dropped while stalled");

  // stalled output transaction keeps payload
  a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_byte) && $stable(out_last)))
    else $error("output payload changed while stalled");

endmodule

bind text_line_filter_with_escapes_top tlf_checker u_tlf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_if.ready),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .out_byte (out_if.out_byte),
  .out_last (out_if.last_of_run)
);

FILE: bench/text_line_filter_with_escapes_top_tb.sv
// self-checking bench for the text line filter: directed table, then random text with stalls
`timescale 1ns / 100ps

module text_line_filter_with_escapes_top_tb;

  localparam int DIGITS           = tlf_pkg::NUMBER_DIGITS_DEF;
  localparam int DRAIN_CYCLES     = 8;
  localparam int HOLD_OFF_CYCLES  = 150;
  localparam int PHASES           = 8;
  localparam int ITEMS_PER_PHASE  = 42;
  localparam int TIMEOUT_NS       = 5_000_000;
  localparam int MAX_PRINTED      = 50;

  // one output byte with its end-of-burst flag
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  // one directed row: settings, input byte, file start and the text it should give
  typedef struct {
    tlf_pkg::cfg_t set;
    logic [7:0]    data;
    logic          sof;
    string         text;
  } dir_row_t;

  // directed settings
  localparam tlf_pkg::cfg_t SET_PLAIN    = '0;
  localparam tlf_pkg::cfg_t SET_NONPRINT = '{show_nonprinting: 1'b1, default: 1'b0};
  localparam tlf_pkg::cfg_t SET_VISIBLE  = '{show_tabs: 1'b1, show_line_ends: 1'b1,
                                             show_nonprinting: 1'b1, default: 1'b0};
  localparam tlf_pkg::cfg_t SET_NUM_SQZ  = '{number_all: 1'b1, squeeze_blank: 1'b1,
                                             show_line_ends: 1'b1, default: 1'b0};
  localparam tlf_pkg::cfg_t SET_NUM_BOTH = '{number_all: 1'b1, number_nonblank: 1'b1,
                                             squeeze_blank: 1'b1, show_line_ends: 1'b1,
                                             default: 1'b0};
  localparam tlf_pkg::cfg_t SET_NONBLANK = '{number_nonblank: 1'b1, squeeze_blank: 1'b1,
                                             show_line_ends: 1'b1, default: 1'b0};
  localparam tlf_pkg::cfg_t SET_ALL      = '1;

  logic clk = 1'b0;
  logic rst_n;
  logic                           cfg_we;
  logic [tlf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tlf_pkg::CFG_DATA_W-1:0] cfg_wdata;

  tlf_in_if  in_ch();
  tlf_out_if out_ch();

  text_line_filter_with_escapes_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // model state of the filter
  tlf_pkg::cfg_t       settings;
  logic                after_nl;
  logic [4*DIGITS-1:0] line_bcd;
  logic [1:0]          blank_run;
  logic [7:0]          burst[$];

  // expected output bytes, oldest first
  out_beat_t pending[$];
  dir_row_t  dir_rows[$];

  int  errors = 0;
  int  items_sent = 0;
  int  beats_seen = 0;
  int  settings_used = 0;
  bit  no_gaps = 1'b0;
  bit  hold_off_req = 1'b0;
  out_beat_t want;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // give up after a generous time
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d output bytes still expected", pending.size());
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // idle length for either side: mostly none or short, a few long
  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // text-like byte with a share of control, meta and arbitrary bytes
  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return tlf_pkg::CH_NL;
    if (r < 30) return tlf_pkg::CH_TAB;
    if (r < 70) return 8'($urandom_range(32, 126));
    if (r < 80) return 8'($urandom_range(0, 31));
    if (r < 88) return 8'($urandom_range(127, 159));
    return 8'($urandom_range(0, 255));
  endfunction

  // compute the output burst of one input byte and advance the line state
  task automatic predict_filter(input logic [7:0] b, input logic sof);
    logic nl;
    logic lead;
    logic all_nines;
    logic carry;
    logic [3:0] d;
    logic [7:0] c;
    logic [4*DIGITS-1:0] nxt;
    burst.delete();
    nl = (b == tlf_pkg::CH_NL);
    c  = b;
    if (sof) begin
      after_nl  = 1'b1;
      line_bcd  = '0;
      blank_run = '0;
    end
    // squeeze check comes before numbering
    if (settings.squeeze_blank) begin
      if (nl && after_nl) begin
        if (blank_run < 2'd2) blank_run++;
        if (blank_run > 2'd1) return;
      end else begin
        blank_run = '0;
      end
    end
    // line number: bcd increment saturating at all nines, then right-aligned digits
    if (after_nl && (settings.number_all || (settings.number_nonblank && !nl))) begin
      all_nines = 1'b1;
      carry = 1'b1;
      nxt = '0;
      for (int i = 0; i < DIGITS; i++) begin
        d = line_bcd[4*i +: 4];
        if (d != 4'd9) all_nines = 1'b0;
        if (carry) begin
          if (d == 4'd9) d = 4'd0;
          else begin
            d = d + 4'd1;
            carry = 1'b0;
          end
        end
        nxt[4*i +: 4] = d;
      end
      if (!all_nines) line_bcd = nxt;
      lead = 1'b1;
      for (int i = DIGITS - 1; i >= 0; i--) begin
        d = line_bcd[4*i +: 4];
        if (d != 4'd0 || i == 0) lead = 1'b0;
        burst.push_back(lead ? tlf_pkg::CH_SPACE : tlf_pkg::CH_ZERO + {4'd0, d});
      end
      burst.push_back(tlf_pkg::CH_TAB);
    end
    if (settings.show_line_ends && nl) burst.push_back(tlf_pkg::CH_DOLLAR);
    // tab display, escapes, then the byte itself
    if (settings.show_tabs && c == tlf_pkg::CH_TAB) begin
      burst.push_back(tlf_pkg::CH_CARET);
      burst.push_back(tlf_pkg::CH_I);
    end else begin
      if (settings.show_nonprinting) begin
        if (c < tlf_pkg::CH_SPACE && c != tlf_pkg::CH_TAB && c != tlf_pkg::CH_NL) begin
          burst.push_back(tlf_pkg::CH_CARET);
          c = c + tlf_pkg::CTRL_OFFSET;
        end else if (c == tlf_pkg::CH_DEL) begin
          burst.push_back(tlf_pkg::CH_CARET);
          c = tlf_pkg::CH_QMARK;
        end else if (c >= tlf_pkg::CH_META_LO && c <= tlf_pkg::CH_META_HI) begin
          burst.push_back(tlf_pkg::CH_M);
          burst.push_back(tlf_pkg::CH_DASH);
          burst.push_back(tlf_pkg::CH_CARET);
          c = c - tlf_pkg::CTRL_OFFSET;
        end
      end
      burst.push_back(c);
    end
    after_nl = nl;
  endtask

  // offer one byte, wait for the transaction, then queue what it should give
  task automatic send_item(input logic [7:0] b, input logic sof, input string text);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= b;
    in_ch.start_of_file <= sof;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_filter(b, sof);
    if (text.len() == 0) begin
      for (int k = 0; k < burst.size(); k++)
        pending.push_back(out_beat_t'{burst[k], k == burst.size() - 1});
    end else begin
      for (int k = 0; k < text.len(); k++)
        pending.push_back(out_beat_t'{text[k], k == text.len() - 1});
    end
    items_sent++;
  endtask

  // stop offering, let every expected byte arrive, then a few quiet cycles
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input tlf_pkg::cfg_idx_t idx, input logic v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  // write all six registers; only called while idle
  task automatic apply_settings(input tlf_pkg::cfg_t s);
    write_reg(tlf_pkg::CFG_NUMBER_ALL, s.number_all);
    write_reg(tlf_pkg::CFG_NUMBER_NONBLANK, s.number_nonblank);
    write_reg(tlf_pkg::CFG_SQUEEZE_BLANK, s.squeeze_blank);
    write_reg(tlf_pkg::CFG_SHOW_LINE_ENDS, s.show_line_ends);
    write_reg(tlf_pkg::CFG_SHOW_TABS, s.show_tabs);
    write_reg(tlf_pkg::CFG_SHOW_NONPRINTING, s.show_nonprinting);
    cfg_we <= 1'b0;
    settings = s;
    settings_used++;
  endtask

  task automatic add_row(input tlf_pkg::cfg_t s, input logic [7:0] d, input logic sof,
                         input string t);
    dir_rows.push_back('{s, d, sof, t});
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int g;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_ch.ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // compare every output transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_seen++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("byte %02h with nothing expected", out_ch.out_byte));
      end else begin
        want = pending.pop_front();
        if (out_ch.out_byte !== want.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    out_ch.out_byte, want.data));
        if (out_ch.last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run %0b, expected %0b on byte %02h",
                                    out_ch.last_of_run, want.last, want.data));
      end
    end
  end

  // stimulus
  initial begin
    int n;
    int run;
    bit held;
    bit paused;
    bit loaded;
    tlf_pkg::cfg_t s;
    dir_row_t row;

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.in_byte       <= '0;
    in_ch.start_of_file <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= tlf_pkg::CFG_NUMBER_ALL;
    cfg_wdata           <= '0;

    settings  = '0;
    after_nl  = 1'b1;
    line_bcd  = '0;
    blank_run = '0;

    // plain pass-through, byte extremes
    add_row(SET_PLAIN, 8'h41, 1'b1, "A");
    add_row(SET_PLAIN, 8'h00, 1'b0, "");
    add_row(SET_PLAIN, 8'hFF, 1'b0, "");
    add_row(SET_PLAIN, tlf_pkg::CH_NL, 1'b0, "\n");
    // caret and meta escapes at the edges of each range
    add_row(SET_NONPRINT, 8'h00, 1'b0, "^@");
    add_row(SET_NONPRINT, 8'h1F, 1'b0, "^_");
    add_row(SET_NONPRINT, tlf_pkg::CH_DEL, 1'b0, "^?");
    add_row(SET_NONPRINT, tlf_pkg::CH_META_LO, 1'b0, "M-^@");
    add_row(SET_NONPRINT, tlf_pkg::CH_META_HI, 1'b0, "M-^_");
    add_row(SET_NONPRINT, 8'hA0, 1'b0, "");
    add_row(SET_NONPRINT, tlf_pkg::CH_TAB, 1'b0, "\t");
    add_row(SET_NONPRINT, tlf_pkg::CH_NL, 1'b0, "\n");
    // visible tab and line end
    add_row(SET_VISIBLE, tlf_pkg::CH_TAB, 1'b0, "^I");
    add_row(SET_VISIBLE, tlf_pkg::CH_NL, 1'b0, "$\n");
    // numbering with squeezed blank lines
    add_row(SET_NUM_SQZ, 8'h78, 1'b1, "     1\tx");
    add_row(SET_NUM_SQZ, tlf_pkg::CH_NL, 1'b0, "$\n");
    add_row(SET_NUM_SQZ, tlf_pkg::CH_NL, 1'b0, "     2\t$\n");
    add_row(SET_NUM_SQZ, tlf_pkg::CH_NL, 1'b0, "");
    add_row(SET_NUM_SQZ, 8'h79, 1'b0, "     3\ty");
    // both numbering modes: all lines wins
    add_row(SET_NUM_BOTH, tlf_pkg::CH_NL, 1'b0, "$\n");
    add_row(SET_NUM_BOTH, tlf_pkg::CH_NL, 1'b0, "     4\t$\n");
    // non-blank numbering restarts at file start
    add_row(SET_NONBLANK, tlf_pkg::CH_NL, 1'b1, "$\n");
    add_row(SET_NONBLANK, 8'h7A, 1'b0, "     1\tz");
    // everything on
    add_row(SET_ALL, tlf_pkg::CH_META_HI, 1'b0, "M-^_");
    add_row(SET_ALL, tlf_pkg::CH_TAB, 1'b0, "^I");

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    loaded = 1'b0;
    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      if (!loaded || row.set != settings) begin
        wait_idle();
        apply_settings(row.set);
        loaded = 1'b1;
      end
      send_item(row.data, row.sof, row.text);
    end

    // random text, a new file at the start of each settings phase and at random points within it
    held = 1'b0;
    paused = 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       s = SET_ALL;
        1:       s = SET_PLAIN;
        2:       s = SET_NUM_SQZ;
        default: s = tlf_pkg::cfg_t'(6'($urandom_range(0, 63)));
      endcase
      wait_idle();
      apply_settings(s);
      no_gaps = (ph == 3);
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        // long receiver hold-off while input keeps coming
        if (ph == 2 && n >= 10 && !held) begin
          hold_off_req = 1'b1;
          held = 1'b1;
        end
        // sender pause until the output side is empty
        if (ph == 5 && n >= 20 && !paused) begin
          wait_idle();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) == 0) begin
          run = $urandom_range(2, 4);
          repeat (run) begin
            send_item(tlf_pkg::CH_NL, n == 0, "");
            n++;
          end
        end else begin
          send_item(pick_text_byte(), (n == 0) || ($urandom_range(0, 49) == 0), "");
          n++;
        end
      end
    end
    no_gaps = 1'b0;

    wait_idle();
    $display("covered %0d input and %0d output transactions over %0d settings,",
             items_sent, beats_seen, settings_used);
    $display("with all options on and off, squeezed and numbered lines, and input stalls");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
